// File: hdl/permanent_weighted_trapezoid_integrator_macros.svh
// Assertion macros shared by the integrator modules.
`ifndef PERMANENT_WEIGHTED_TRAPEZOID_INTEGRATOR_MACROS_SVH
`define PERMANENT_WEIGHTED_TRAPEZOID_INTEGRATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold on every clock edge outside reset.
`define PWTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define PWTI_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define PWTI_ASSERT(lbl, prop, msg)
`define PWTI_NEVER(lbl, expr, msg)
`endif
`endif

// File: hdl/pwti_pkg.sv
// Types, constants and arithmetic helpers of the trapezoid integrator.
package pwti_pkg;

  localparam int unsigned QW      = 32;         // Q4.27 word
  localparam int unsigned QFrac   = 27;
  localparam int unsigned ThrW    = 31;
  localparam int unsigned StepW   = 31;
  localparam int unsigned CntW    = 4;
  localparam int unsigned AccW    = 64;         // Q16.47 accumulator
  localparam int unsigned MulW    = QW + 2;     // fits step x (sample sum)
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned PermW   = QW + 3;     // exact sum of six terms
  localparam int unsigned NumBasis = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned AreaShift = 8;
  localparam int unsigned RoundQ    = 1 << (QFrac - 1);
  localparam int unsigned RoundArea = 1 << (AreaShift - 1);

  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COUNT     = 2'd1;

  localparam logic [CntW-1:0] COUNT_RESET = 4'd10;
  localparam logic [CntW-1:0] IDX_MAX     = 4'd15;
  localparam logic signed [QW-1:0] SIXTH_Q = 32'sd22369621;

  localparam int unsigned NumSlots = 20;
  localparam int unsigned SlotW    = $clog2(NumSlots);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5,
    OP_XX,
    OP_T0, OP_T1, OP_T2, OP_T3, OP_T4, OP_T5,
    OP_S1,
    OP_Y,
    OP_AREA
  } op_e;

  typedef struct packed {
    logic load;      // input transaction taken
    op_e  op;        // multiply issued this cycle
    logic commit;    // update running state
    logic out_load;  // capture integral into output register
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

  typedef struct packed {
    logic signed [QW-1:0] val;
    logic                 sat;
  } qres_t;

  // Multiply schedule. Each product is registered, then written back.
  function automatic op_e sched_op(input logic [SlotW-1:0] slot);
    op_e op;
    unique case (slot)
      5'd0:    op = OP_M0;
      5'd1:    op = OP_M1;
      5'd2:    op = OP_M2;
      5'd3:    op = OP_M3;
      5'd4:    op = OP_M4;
      5'd5:    op = OP_M5;
      5'd6:    op = OP_XX;
      5'd7:    op = OP_T0;
      5'd8:    op = OP_T1;
      5'd9:    op = OP_T2;
      5'd10:   op = OP_T3;
      5'd11:   op = OP_T4;
      5'd12:   op = OP_T5;
      5'd14:   op = OP_S1;
      5'd16:   op = OP_Y;
      5'd18:   op = OP_AREA;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  // Round half up, floor shift by QFrac, saturate to Q4.27.
  function automatic qres_t round_q(input logic signed [ProdW-1:0] prod);
    logic signed [ProdW-1:0] sum;
    logic signed [ProdW-1:0] sh;
    qres_t r;
    sum = prod + $signed(ProdW'(RoundQ));
    sh  = sum >>> QFrac;
    if ((sh[ProdW-1:QW-1] == '0) || (sh[ProdW-1:QW-1] == '1)) begin
      r.val = sh[QW-1:0];
      r.sat = 1'b0;
    end else begin
      r.val = sh[ProdW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      r.sat = 1'b1;
    end
    return r;
  endfunction

  function automatic qres_t sat_perm(input logic signed [PermW-1:0] v);
    qres_t r;
    if ((v[PermW-1:QW-1] == '0) || (v[PermW-1:QW-1] == '1)) begin
      r.val = v[QW-1:0];
      r.sat = 1'b0;
    end else begin
      r.val = v[PermW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: hdl/pwti_mul.sv
// Shared signed multiplier with registered product.
module pwti_mul (
  input  logic                                clk_i,
  input  logic signed [pwti_pkg::MulW-1:0]    a_i,
  input  logic signed [pwti_pkg::MulW-1:0]    b_i,
  output logic signed [pwti_pkg::ProdW-1:0]   prod_o
);
  import pwti_pkg::*;

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// File: hdl/pwti_ctrl.sv
// Sequencer of the integrator: handshakes and multiply schedule.
`include "permanent_weighted_trapezoid_integrator_macros.svh"
module pwti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pwti_pkg::cmd_t    cmd_o,
  input  pwti_pkg::sts_t    sts_i
);
  import pwti_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_POST} state_e;

  state_e           state_q;
  logic [SlotW-1:0] slot_q;
  logic             out_valid_q;
  logic             accept;
  logic             commit;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // a last point waits here while the previous integral is still unread
  assign commit     = (state_q == S_POST) && (!sts_i.last || !out_valid_q || out_ready_i);

  assign cmd_o.load     = accept;
  assign cmd_o.op       = (state_q == S_RUN) ? sched_op(slot_q) : OP_NONE;
  assign cmd_o.commit   = commit;
  assign cmd_o.out_load = commit && sts_i.last;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_RUN;
            slot_q  <= '0;
          end
        end
        S_RUN: begin
          slot_q <= slot_q + 1'b1;
          if (slot_q == SlotW'(NumSlots - 1)) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `PWTI_ASSERT(a_accept_starts_run, accept |=> (state_q == S_RUN) && (slot_q == '0), "run did not start at slot zero")
  `PWTI_ASSERT(a_out_from_post, $rose(out_valid_q) |-> $past(state_q == S_POST), "result raised outside post step")
  `PWTI_NEVER(a_no_op_outside_run, (state_q != S_RUN) && (cmd_o.op != OP_NONE), "multiply issued outside run")

endmodule

// File: hdl/pwti_dp.sv
// Datapath: operand select, rounding, permanent sum, trapezoid accumulator.
`include "permanent_weighted_trapezoid_integrator_macros.svh"
module pwti_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pwti_pkg::cmd_t                         cmd_i,
  output pwti_pkg::sts_t                         sts_o,
  input  logic                                   cfg_valid_i,
  input  logic [pwti_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [pwti_pkg::CfgDataW-1:0]          cfg_data_i,
  input  logic signed [pwti_pkg::QW-1:0]         basis_i [pwti_pkg::NumBasis],
  input  logic signed [pwti_pkg::QW-1:0]         x_value_i,
  input  logic [pwti_pkg::StepW-1:0]             x_step_i,
  input  logic                                   last_i,
  output logic signed [pwti_pkg::AccW-1:0]       integral_o,
  output logic                                   saturated_o
);
  import pwti_pkg::*;

  // operand latches
  logic signed [QW-1:0]    p_q [NumBasis];
  logic signed [QW-1:0]    x_q;
  logic [StepW-1:0]        step_q;
  logic                    last_q;
  // intermediate results
  logic signed [QW-1:0]    m_q [6];
  logic signed [QW-1:0]    xx_q;
  logic signed [PermW-1:0] perm_q;
  logic signed [QW-1:0]    s1_q;
  logic signed [QW-1:0]    y_q;
  // running state
  logic [ThrW-1:0]         thr_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [QW-1:0]    prev_sample_q;
  logic [StepW-1:0]        prev_step_q;
  logic                    have_prev_q;
  logic [CntW-1:0]         idx_q;
  logic signed [AccW-1:0]  acc_q;
  logic                    ovf_q;
  op_e                     wb_op_q;
  logic signed [AccW-1:0]  integral_q;
  logic                    saturated_q;

  logic signed [MulW-1:0]  mul_a;
  logic signed [MulW-1:0]  mul_b;
  logic signed [ProdW-1:0] prod;
  qres_t                   qr;
  qres_t                   perm_sat;
  logic signed [QW:0]      pair_sum;
  logic signed [QW:0]      y_ext;
  logic [QW:0]             y_mag;
  logic                    rogue;
  logic signed [ProdW-1:0] area_full;
  logic signed [AccW-1:0]  area;
  logic signed [AccW:0]    acc_sum;
  logic                    acc_sat;
  logic signed [AccW-1:0]  acc_next;
  logic                    ovf_set;

  function automatic logic signed [MulW-1:0] ext_q(input logic signed [QW-1:0] v);
    return {{(MulW-QW){v[QW-1]}}, v};
  endfunction

  assign perm_sat = sat_perm(perm_q);
  assign pair_sum = {prev_sample_q[QW-1], prev_sample_q} + {y_q[QW-1], y_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_M0:   begin mul_a = ext_q(p_q[0]); mul_b = ext_q(p_q[4]); end
      OP_M1:   begin mul_a = ext_q(p_q[1]); mul_b = ext_q(p_q[5]); end
      OP_M2:   begin mul_a = ext_q(p_q[2]); mul_b = ext_q(p_q[3]); end
      OP_M3:   begin mul_a = ext_q(p_q[2]); mul_b = ext_q(p_q[4]); end
      OP_M4:   begin mul_a = ext_q(p_q[1]); mul_b = ext_q(p_q[3]); end
      OP_M5:   begin mul_a = ext_q(p_q[0]); mul_b = ext_q(p_q[5]); end
      OP_XX:   begin mul_a = ext_q(x_q);    mul_b = ext_q(x_q);    end
      OP_T0:   begin mul_a = ext_q(m_q[0]); mul_b = ext_q(p_q[8]); end
      OP_T1:   begin mul_a = ext_q(m_q[1]); mul_b = ext_q(p_q[6]); end
      OP_T2:   begin mul_a = ext_q(m_q[2]); mul_b = ext_q(p_q[7]); end
      OP_T3:   begin mul_a = ext_q(m_q[3]); mul_b = ext_q(p_q[6]); end
      OP_T4:   begin mul_a = ext_q(m_q[4]); mul_b = ext_q(p_q[8]); end
      OP_T5:   begin mul_a = ext_q(m_q[5]); mul_b = ext_q(p_q[7]); end
      OP_S1:   begin mul_a = ext_q(xx_q);   mul_b = ext_q(perm_sat.val); end
      OP_Y:    begin mul_a = ext_q(s1_q);   mul_b = ext_q(SIXTH_Q); end
      OP_AREA: begin
        mul_a = {{(MulW-StepW){1'b0}}, prev_step_q};
        mul_b = {{(MulW-QW-1){pair_sum[QW]}}, pair_sum};
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  pwti_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // writeback arithmetic
  always_comb begin
    qr        = round_q(prod);
    y_ext     = {qr.val[QW-1], qr.val};
    y_mag     = y_ext[QW] ? (~y_ext + 1'b1) : y_ext;
    rogue     = (idx_q < cnt_q) && (y_mag > {2'b00, thr_q});
    area_full = (prod + $signed(ProdW'(RoundArea))) >>> AreaShift;
    area      = area_full[AccW-1:0];
    acc_sum   = {acc_q[AccW-1], acc_q} + {area[AccW-1], area};
    acc_sat   = (acc_sum[AccW] != acc_sum[AccW-1]);
    if (!acc_sat) begin
      acc_next = acc_sum[AccW-1:0];
    end else if (acc_sum[AccW]) begin
      acc_next = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      acc_next = {1'b0, {(AccW-1){1'b1}}};
    end
    ovf_set = 1'b0;
    unique case (wb_op_q)
      OP_NONE: ovf_set = 1'b0;
      OP_AREA: ovf_set = have_prev_q && acc_sat;
      default: ovf_set = qr.sat;
    endcase
    if ((cmd_i.op == OP_S1) && perm_sat.sat) begin
      ovf_set = 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q    <= basis_i;
      x_q    <= x_value_i;
      step_q <= x_step_i;
      last_q <= last_i;
      perm_q <= '0;
    end
    unique case (wb_op_q)
      OP_M0:   m_q[0] <= qr.val;
      OP_M1:   m_q[1] <= qr.val;
      OP_M2:   m_q[2] <= qr.val;
      OP_M3:   m_q[3] <= qr.val;
      OP_M4:   m_q[4] <= qr.val;
      OP_M5:   m_q[5] <= qr.val;
      OP_XX:   xx_q   <= qr.val;
      OP_T0, OP_T1, OP_T2, OP_T3, OP_T4, OP_T5: begin
        perm_q <= perm_q + {{(PermW-QW){qr.val[QW-1]}}, qr.val};
      end
      OP_S1:   s1_q <= qr.val;
      OP_Y:    y_q  <= rogue ? '0 : qr.val;
      default: ;
    endcase
    if (cmd_i.out_load) begin
      integral_q  <= acc_q;
      saturated_q <= ovf_q;
    end
  end

  // config and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q         <= '0;
      cnt_q         <= COUNT_RESET;
      prev_sample_q <= '0;
      prev_step_q   <= '0;
      have_prev_q   <= 1'b0;
      idx_q         <= '0;
      acc_q         <= '0;
      ovf_q         <= 1'b0;
      wb_op_q       <= OP_NONE;
    end else begin
      wb_op_q <= cmd_i.op;
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_THRESHOLD) begin
          thr_q <= cfg_data_i[ThrW-1:0];
        end else if (cfg_index_i == CFG_COUNT) begin
          cnt_q <= cfg_data_i[CntW-1:0];
        end
      end
      if ((wb_op_q == OP_AREA) && have_prev_q) begin
        acc_q <= acc_next;
      end
      if (cmd_i.commit) begin
        if (last_q) begin
          prev_sample_q <= '0;
          prev_step_q   <= '0;
          have_prev_q   <= 1'b0;
          idx_q         <= '0;
          acc_q         <= '0;
        end else begin
          prev_sample_q <= y_q;
          prev_step_q   <= step_q;
          have_prev_q   <= 1'b1;
          if (idx_q != IDX_MAX) begin
            idx_q <= idx_q + 1'b1;
          end
        end
      end
      if (cmd_i.out_load) begin
        ovf_q <= 1'b0;
      end else if (ovf_set) begin
        ovf_q <= 1'b1;
      end
    end
  end

  assign sts_o.last  = last_q;
  assign integral_o  = integral_q;
  assign saturated_o = saturated_q;

  `PWTI_ASSERT(a_clear_after_last, cmd_i.out_load |=> (acc_q == '0) && !ovf_q && !have_prev_q, "integral state not cleared")
  `PWTI_ASSERT(a_idx_tracks_prev, have_prev_q |-> (idx_q != '0), "sample index lost while history held")
  `PWTI_ASSERT(a_commit_no_writeback, cmd_i.commit |-> (wb_op_q == OP_NONE), "commit overlaps a writeback")

endmodule

// File: hdl/permanent_weighted_trapezoid_integrator.sv
// Top level of the permanent-weighted trapezoid integrator.
// Grid points are taken one at a time; the single shared multiplier runs a
//   schedule of 16 products per point, with dependency gaps, before commit.
// A last point loads the integral into the output register at its commit;
//   it waits in the post step for as long as its prior result sits unread.
// Reset (async, active low): accumulator, history and flags clear,
//   rogue_threshold = 0, rogue_count = 10, no result pending.
module permanent_weighted_trapezoid_integrator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // grid point channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [pwti_pkg::QW-1:0]       basis_r1_c1_i,
  input  logic signed [pwti_pkg::QW-1:0]       basis_r1_c2_i,
  input  logic signed [pwti_pkg::QW-1:0]       basis_r1_c3_i,
  input  logic signed [pwti_pkg::QW-1:0]       basis_r2_c1_i,
  input  logic signed [pwti_pkg::QW-1:0]       basis_r2_c2_i,
  input  logic signed [pwti_pkg::QW-1:0]       basis_r2_c3_i,
  input  logic signed [pwti_pkg::QW-1:0]       basis_r3_c1_i,
  input  logic signed [pwti_pkg::QW-1:0]       basis_r3_c2_i,
  input  logic signed [pwti_pkg::QW-1:0]       basis_r3_c3_i,
  input  logic signed [pwti_pkg::QW-1:0]       x_value_i,
  input  logic [pwti_pkg::StepW-1:0]           x_step_i,
  input  logic                                 last_i,
  // integral channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [pwti_pkg::AccW-1:0]     integral_o,
  output logic                                 saturated_o,
  // register write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pwti_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [pwti_pkg::CfgDataW-1:0]        cfg_data_i
);
  import pwti_pkg::*;

  cmd_t                 cmd;
  sts_t                 sts;
  logic signed [QW-1:0] basis [NumBasis];

  // Basis matrix in row order: p0..p8.
  assign basis[0] = basis_r1_c1_i;
  assign basis[1] = basis_r1_c2_i;
  assign basis[2] = basis_r1_c3_i;
  assign basis[3] = basis_r2_c1_i;
  assign basis[4] = basis_r2_c2_i;
  assign basis[5] = basis_r2_c3_i;
  assign basis[6] = basis_r3_c1_i;
  assign basis[7] = basis_r3_c2_i;
  assign basis[8] = basis_r3_c3_i;

  // Register writes are always accepted and land directly in the config registers; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  // Controller: accepts a transaction, walks the multiply schedule,
  // then commits history and, on a last point, loads the output register.
  pwti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: permanent as six two-step products summed exactly, then
  // sample = x^2 * perm * 1/6 with rogue zeroing, then trapezoid area
  // prev_step * (prev_sample + sample) / 2 into the saturating Q16.47 sum.
  pwti_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .basis_i     (basis),
    .x_value_i   (x_value_i),
    .x_step_i    (x_step_i),
    .last_i      (last_i),
    .integral_o  (integral_o),
    .saturated_o (saturated_o)
  );

endmodule
